/* rtl/cms_pkg.sv */
// package for the capture move score sorter: payload types, codes and the score table
`timescale 1ns / 1ps
package cms_pkg;

   // list capacity, number of cells in the insertion chain
   localparam int MAX_MOVES = 64;

   localparam int TAG_W   = 16;
   localparam int SCORE_W = 13;
   localparam int PROMO_W = 12;
   localparam int TYPE_W  = 3;
   localparam int KIND_W  = 2;
   localparam int PIECE_W = 2;
   localparam int CSR_IDX_W = 2;

   // move kinds
   localparam logic [KIND_W-1:0] KIND_NORMAL     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROMOTION  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EN_PASSANT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CASTLING   = 2'd3;

   // piece type codes
   localparam logic [TYPE_W-1:0] PIECE_PAWN = 3'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROMO_KNIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMO_BISHOP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMO_ROOK   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMO_QUEEN  = 2'd3;

   // register reset values
   localparam logic [PROMO_W-1:0] PROMO_KNIGHT_RST = 12'd320;
   localparam logic [PROMO_W-1:0] PROMO_BISHOP_RST = 12'd330;
   localparam logic [PROMO_W-1:0] PROMO_ROOK_RST   = 12'd500;
   localparam logic [PROMO_W-1:0] PROMO_QUEEN_RST  = 12'd900;

   // victim/attacker table, indexed by {victim, attacker}
   localparam logic [5:0] CAPTURE_SCORES [64] = '{
      6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd0, 6'd0,
      6'd25, 6'd24, 6'd23, 6'd22, 6'd21, 6'd20, 6'd0, 6'd0,
      6'd35, 6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd0, 6'd0,
      6'd45, 6'd44, 6'd43, 6'd42, 6'd41, 6'd40, 6'd0, 6'd0,
      6'd55, 6'd54, 6'd53, 6'd52, 6'd51, 6'd50, 6'd0, 6'd0,
      6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0,
      6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0,
      6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0
   };

   typedef struct packed {
      logic [TAG_W-1:0]   move_tag;
      logic [TYPE_W-1:0]  attacker_type;
      logic [TYPE_W-1:0]  victim_type;
      logic [KIND_W-1:0]  move_kind;
      logic [PIECE_W-1:0] promo_piece;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]   sorted_tag;
      logic [SCORE_W-1:0] move_score;
      logic               last_out;
      logic               overflowed;
   } rsp_type;

   // one stored move
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // broadcast control for every cell of the chain
   typedef struct packed {
      logic               insert;
      logic               pop;
      logic [TAG_W-1:0]   new_tag;
      logic [SCORE_W-1:0] new_score;
   } cell_ctrl_type;

   typedef logic [3:0][PROMO_W-1:0] promo_vals_type;

endpackage

/* rtl/cms_score.sv */
// move scorer: table lookup by victim and attacker plus promotion bonus
`timescale 1ns / 1ps
module cms_score (
   input  cms_pkg::req_type          req,
   input  cms_pkg::promo_vals_type   promo_vals,
   output logic [cms_pkg::SCORE_W-1:0] score
);
   import cms_pkg::*;

   logic [TYPE_W-1:0]  victim_eff;
   logic [5:0]         table_score;
   logic [SCORE_W-1:0] bonus;

   // en passant captures a pawn
   always_comb begin
      victim_eff = (req.move_kind == KIND_EN_PASSANT) ? PIECE_PAWN : req.victim_type;
      table_score = CAPTURE_SCORES[{victim_eff, req.attacker_type}];
   end

   // promotion bonus only on promotion moves
   always_comb begin
      if (req.move_kind == KIND_PROMOTION) begin
         bonus = {1'b0, promo_vals[req.promo_piece]};
      end else begin
         bonus = '0;
      end
      score = bonus + {{(SCORE_W-6){1'b0}}, table_score};
   end

endmodule

/* rtl/cms_cell.sv */
// one cell of the sorted insertion chain
`timescale 1ns / 1ps
module cms_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  cms_pkg::cell_ctrl_type  ctrl,
   input  cms_pkg::entry_type      prev_entry,
   input  logic                    prev_ins,
   input  cms_pkg::entry_type      next_entry,
   output cms_pkg::entry_type      entry,
   output logic                    ins
);
   import cms_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new move belongs at or above this cell; ties stay behind
   assign ins   = !entry_ff.valid || (entry_ff.score < ctrl.new_score);
   assign entry = entry_ff;

   // shift down on insert, shift up on pop
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = next_entry;
      end else if (ctrl.insert) begin
         if (prev_ins) begin
            entry_in = prev_entry;
         end else if (ins) begin
            entry_in.valid = 1'b1;
            entry_in.tag   = ctrl.new_tag;
            entry_in.score = ctrl.new_score;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

/* rtl/capture_move_score_sorter.sv */
// capture move score sorter top level: scoring stage, insertion chain, emission
//
// Moves of one list arrive on the req_ channel, one transaction each, and are
// accepted one per cycle while the block is loading. Each move is scored into a
// register stage and from there inserted into a chain of MAX_MOVES cells
// that keeps the list in descending score order, equal scores in load order.
// A move arriving while every cell is full is dropped and the list is flagged.
// The move marked last_in ends the list: once it has left the scoring stage the
// first result is on rsp_, and the chain then shifts one result out per cycle
// as rsp_ready allows. req_ready is low from the last move until the final
// result is taken. When the receiver stalls, the head result holds on
// rsp_payload and the chain holds. csr_ writes set the promotion bonuses and
// take effect on the next accepted move. Reset empties the chain, clears the
// drop flag and restores the bonus defaults.
`timescale 1ns / 1ps
module capture_move_score_sorter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cms_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cms_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write,
   input  logic [cms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cms_pkg::PROMO_W-1:0]      csr_data
);
   import cms_pkg::*;

   promo_vals_type promo_ff;
   promo_vals_type promo_in;

   logic               stage_valid_ff, stage_valid_in;
   logic               stage_last_ff;
   logic [TAG_W-1:0]   stage_tag_ff;
   logic [SCORE_W-1:0] stage_score_ff;
   logic [SCORE_W-1:0] req_score;

   logic emit_ff, emit_in;
   logic drop_ff, drop_in;

   entry_type     cell_entry [MAX_MOVES];
   logic          cell_ins   [MAX_MOVES];
   entry_type     prev_entry [MAX_MOVES];
   logic          prev_ins   [MAX_MOVES];
   entry_type     next_entry [MAX_MOVES];
   cell_ctrl_type ctrl;

   logic req_fire, rsp_fire, full, list_done;

   // configuration registers
   always_comb begin
      promo_in = promo_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PROMO_KNIGHT: promo_in[0] = csr_data;
            CSR_PROMO_BISHOP: promo_in[1] = csr_data;
            CSR_PROMO_ROOK:   promo_in[2] = csr_data;
            CSR_PROMO_QUEEN:  promo_in[3] = csr_data;
            default:          promo_in = promo_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         promo_ff[0] <= PROMO_KNIGHT_RST;
         promo_ff[1] <= PROMO_BISHOP_RST;
         promo_ff[2] <= PROMO_ROOK_RST;
         promo_ff[3] <= PROMO_QUEEN_RST;
      end else begin
         promo_ff <= promo_in;
      end
   end

   // handshakes
   assign req_ready = !emit_ff && !(stage_valid_ff && stage_last_ff);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = emit_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign full      = cell_entry[MAX_MOVES-1].valid;
   assign list_done = rsp_fire && !cell_entry[1].valid;

   // scoring stage
   cms_score u_score (
      .req        (req_payload),
      .promo_vals (promo_ff),
      .score      (req_score)
   );

   assign stage_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_tag_ff   <= req_payload.move_tag;
         stage_score_ff <= req_score;
         stage_last_ff  <= req_payload.last_in;
      end
   end

   // emission and drop flag control
   always_comb begin
      emit_in = emit_ff;
      drop_in = drop_ff;
      if (stage_valid_ff && full) begin
         drop_in = 1'b1;
      end
      if (stage_valid_ff && stage_last_ff) begin
         emit_in = 1'b1;
      end
      if (list_done) begin
         emit_in = 1'b0;
         drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         emit_ff <= emit_in;
         drop_ff <= drop_in;
      end
   end

   // broadcast to the chain
   always_comb begin
      ctrl.insert    = stage_valid_ff && !full;
      ctrl.pop       = rsp_fire;
      ctrl.new_tag   = stage_tag_ff;
      ctrl.new_score = stage_score_ff;
   end

   // neighbor wiring
   always_comb begin
      for (int i = 0; i < MAX_MOVES; i++) begin
         if (i == 0) begin
            prev_entry[i] = '0;
            prev_ins[i]   = 1'b0;
         end else begin
            prev_entry[i] = cell_entry[i-1];
            prev_ins[i]   = cell_ins[i-1];
         end
         if (i == MAX_MOVES-1) begin
            next_entry[i] = '0;
         end else begin
            next_entry[i] = cell_entry[i+1];
         end
      end
   end

   // insertion chain
   for (genvar g = 0; g < MAX_MOVES; g++) begin : g_cell
      cms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_entry[g]),
         .prev_ins   (prev_ins[g]),
         .next_entry (next_entry[g]),
         .entry      (cell_entry[g]),
         .ins        (cell_ins[g])
      );
   end

   // head of the chain is the output
   always_comb begin
      rsp_payload.sorted_tag = cell_entry[0].tag;
      rsp_payload.move_score = cell_entry[0].score;
      rsp_payload.last_out   = !cell_entry[1].valid;
      rsp_payload.overflowed = drop_ff;
   end

endmodule

/* tb/cms_order_checker.sv */
// scoreboard for the capture move score sorter: scores loaded moves, predicts sorted lists, checks results
`timescale 1ns / 1ps
module cms_order_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  cms_pkg::req_type              req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  cms_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write,
   input  logic [cms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cms_pkg::PROMO_W-1:0]   csr_data,
   output int                            fail_count,
   output int                            pending
);

   // highest piece codes that still score as victim and as attacker
   localparam logic [cms_pkg::TYPE_W-1:0] PIECE_QUEEN = 3'd4;
   localparam logic [cms_pkg::TYPE_W-1:0] PIECE_KING  = 3'd5;

   typedef struct packed {
      logic [cms_pkg::TAG_W-1:0]   tag;
      logic [cms_pkg::SCORE_W-1:0] score;
   } scored_move_type;

   logic [cms_pkg::PROMO_W-1:0] bonus [4];
   scored_move_type             loaded_moves [$];   // kept in descending score order
   logic                        list_dropped;
   cms_pkg::rsp_type            results_due [$];

   // victim/attacker score plus the promotion bonus
   function automatic logic [cms_pkg::SCORE_W-1:0] capture_score(input cms_pkg::req_type m);
      logic [cms_pkg::TYPE_W-1:0]  victim;
      int                          base;
      logic [cms_pkg::SCORE_W-1:0] total;
      victim = (m.move_kind == cms_pkg::KIND_EN_PASSANT) ? cms_pkg::PIECE_PAWN : m.victim_type;
      base = 0;
      if (victim <= PIECE_QUEEN && m.attacker_type <= PIECE_KING) begin
         base = 10 * (int'(victim) + 1) + 5 - int'(m.attacker_type);
      end
      total = base[cms_pkg::SCORE_W-1:0];
      if (m.move_kind == cms_pkg::KIND_PROMOTION) begin
         total = total + {{(cms_pkg::SCORE_W - cms_pkg::PROMO_W){1'b0}}, bonus[m.promo_piece]};
      end
      return total;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // insert behind every move of equal or higher score, emit the list on last_in
   task automatic load_move(input cms_pkg::req_type m);
      scored_move_type  mv;
      cms_pkg::rsp_type r;
      int               pos;
      if (loaded_moves.size() < cms_pkg::MAX_MOVES) begin
         mv.tag   = m.move_tag;
         mv.score = capture_score(m);
         pos = loaded_moves.size();
         while (pos > 0 && loaded_moves[pos - 1].score < mv.score) pos--;
         loaded_moves.insert(pos, mv);
      end else begin
         list_dropped = 1'b1;
      end
      if (m.last_in) begin
         foreach (loaded_moves[i]) begin
            r.sorted_tag = loaded_moves[i].tag;
            r.move_score = loaded_moves[i].score;
            r.last_out   = (i == loaded_moves.size() - 1);
            r.overflowed = list_dropped;
            results_due.push_back(r);
         end
         loaded_moves.delete();
         list_dropped = 1'b0;
      end
   endtask

   // compare one result transaction with the oldest one due
   task automatic check_result(input cms_pkg::rsp_type got);
      cms_pkg::rsp_type want;
      string            fields;
      if (results_due.size() == 0) begin
         report_mismatch($sformatf("result with none due: tag %h score %0d",
                                   got.sorted_tag, got.move_score));
      end else begin
         want = results_due.pop_front();
         fields = "";
         if (got.sorted_tag !== want.sorted_tag) fields = {fields, " sorted_tag"};
         if (got.move_score !== want.move_score) fields = {fields, " move_score"};
         if (got.last_out !== want.last_out)     fields = {fields, " last_out"};
         if (got.overflowed !== want.overflowed) fields = {fields, " overflowed"};
         if (fields != "") begin
            report_mismatch($sformatf("mismatch in%s: got %h/%0d/%b/%b, expected %h/%0d/%b/%b",
               fields, got.sorted_tag, got.move_score, got.last_out, got.overflowed,
               want.sorted_tag, want.move_score, want.last_out, want.overflowed));
         end
      end
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         bonus[cms_pkg::CSR_PROMO_KNIGHT] = cms_pkg::PROMO_KNIGHT_RST;
         bonus[cms_pkg::CSR_PROMO_BISHOP] = cms_pkg::PROMO_BISHOP_RST;
         bonus[cms_pkg::CSR_PROMO_ROOK]   = cms_pkg::PROMO_ROOK_RST;
         bonus[cms_pkg::CSR_PROMO_QUEEN]  = cms_pkg::PROMO_QUEEN_RST;
         loaded_moves.delete();
         results_due.delete();
         list_dropped = 1'b0;
      end else begin
         if (csr_write) bonus[csr_index] = csr_data;
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (req_valid && req_ready) load_move(req_payload);
      end
      pending <= results_due.size();
   end

endmodule

/* tb/tb_top.sv */
// testbench top for the capture move score sorter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_LATE} stall_mode_type;

   localparam logic [cms_pkg::KIND_W-1:0] KIND_ORDER [4] = '{
      cms_pkg::KIND_NORMAL, cms_pkg::KIND_PROMOTION,
      cms_pkg::KIND_EN_PASSANT, cms_pkg::KIND_CASTLING
   };
   localparam logic [cms_pkg::CSR_IDX_W-1:0] BONUS_INDEX [4] = '{
      cms_pkg::CSR_PROMO_KNIGHT, cms_pkg::CSR_PROMO_BISHOP,
      cms_pkg::CSR_PROMO_ROOK, cms_pkg::CSR_PROMO_QUEEN
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   cms_pkg::req_type              req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   cms_pkg::rsp_type              rsp_payload;
   logic                          csr_write = 1'b0;
   logic [cms_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cms_pkg::PROMO_W-1:0]   csr_data = '0;
   int                            fail_count;
   int                            pending;

   int                            burst_left = 0;
   stall_mode_type                stall_mode = READY_ALWAYS;
   logic [4:0]                    stall_phase = '0;

   always #6 clock = ~clock;

   capture_move_score_sorter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   cms_order_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   function automatic cms_pkg::req_type make_move(input int tag, input int attacker,
                                                  input int victim, input int kind,
                                                  input int promo, input bit last);
      cms_pkg::req_type m;
      m.move_tag      = tag[cms_pkg::TAG_W-1:0];
      m.attacker_type = attacker[cms_pkg::TYPE_W-1:0];
      m.victim_type   = victim[cms_pkg::TYPE_W-1:0];
      m.move_kind     = kind[cms_pkg::KIND_W-1:0];
      m.promo_piece   = promo[cms_pkg::PIECE_W-1:0];
      m.last_in       = last;
      return m;
   endfunction

   // one move transaction, then maybe an idle gap at the end of a burst
   task automatic send_move(input cms_pkg::req_type m);
      req_valid   <= 1'b1;
      req_payload <= m;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 7);
      end
   endtask

   // drop valid and wait until every predicted result has been taken
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (settle) @(posedge clock);
   endtask

   // write the bonus registers selected by mask, one per cycle
   task automatic program_bonuses(input cms_pkg::promo_vals_type vals, input logic [3:0] mask);
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            csr_write <= 1'b1;
            csr_index <= BONUS_INDEX[i];
            csr_data  <= vals[i];
            @(posedge clock);
         end
      end
      csr_write <= 1'b0;
   endtask

   // receiver stalls, pattern chosen anew each time the 5-bit phase counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_phase == 5'd0) stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_phase = stall_phase + 5'd1;
         case (stall_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ready <= (stall_phase >= 5'd20);
         endcase
      end
   end

   // stimulus and verdict
   initial begin
      cms_pkg::promo_vals_type vals;
      int                      list_len;
      int                      list_no;
      int                      overflow_list;
      int                      random_items;
      int                      word;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // table corners, type code seven, king and empty victims, every kind, reset bonuses
      for (int i = 0; i < 8; i++) begin
         send_move(make_move(16'h1111 * i, i, i, cms_pkg::KIND_NORMAL, i, 1'b0));
      end
      for (int i = 0; i < 8; i++) begin
         send_move(make_move(16'hFFFF - 16'h1111 * (7 - i), 7 - i, i, KIND_ORDER[i % 4],
                             i / 2, i == 7));
      end

      // every promotion piece under two extreme bonus settings, bonus skipped on a normal move
      for (int s = 0; s < 2; s++) begin
         wait_idle(4);
         vals[0] = (s == 0) ? 12'hFFF : 12'h000;
         vals[1] = (s == 0) ? 12'h000 : 12'hFFF;
         vals[2] = (s == 0) ? 12'hAAA : 12'h555;
         vals[3] = (s == 0) ? 12'h555 : 12'hAAA;
         program_bonuses(vals, 4'hF);
         for (int p = 0; p < 4; p++) begin
            send_move(make_move($urandom_range(0, 65535), cms_pkg::PIECE_PAWN, p * 2,
                                cms_pkg::KIND_PROMOTION, p, 1'b0));
         end
         send_move(make_move($urandom_range(0, 65535), cms_pkg::PIECE_PAWN, 4,
                             cms_pkg::KIND_NORMAL, 3, 1'b1));
      end

      // single move list
      send_move(make_move(16'h5AA5, 1, 3, cms_pkg::KIND_CASTLING, 2, 1'b1));

      // random lists, one of them past capacity with last_in on a dropped move
      random_items = 0;
      list_no = 0;
      overflow_list = $urandom_range(0, 2);
      while (random_items < 12 || list_no <= overflow_list) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_idle(4);
            for (int r = 0; r < 4; r++) begin
               word = $urandom_range(0, 4095);
               case ($urandom_range(0, 3))
                  0:       vals[r] = 12'h000;
                  1:       vals[r] = 12'hFFF;
                  default: vals[r] = word[cms_pkg::PROMO_W-1:0];
               endcase
            end
            program_bonuses(vals, 4'($urandom_range(1, 15)));
         end
         list_len = (list_no == overflow_list) ? cms_pkg::MAX_MOVES + 2 : $urandom_range(1, 10);
         for (int k = 0; k < list_len; k++) begin
            send_move(make_move($urandom_range(0, 65535), $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom_range(0, 3),
                                $urandom_range(0, 3), k == list_len - 1));
         end
         if (list_no != overflow_list) random_items += list_len;
         list_no++;
      end

      wait_idle(20);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
